// ----- hw/rtl/fbpa_pkg.sv -----
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int NUM_BLOCKS_DEF  = 32;
    localparam int BLOCK_BYTES_DEF = 128;
    localparam int ADDR_W          = 32;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_REFUSED = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic walk_step;
        logic top_read;
        logic mul;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_last;
        logic walk_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ----- hw/rtl/fixed_block_pool_allocator_top.sv -----
`timescale 1ns / 1ps
// channel   | dir | handshake          | payload
// ----------+-----+--------------------+--------------------------------------------
// config    | in  | cfg_we             | cfg_wdata = pool_base
// request   | in  | s_tvalid/s_tready  | s_tuser = command, s_tdata = block_address
// result    | out | m_tvalid/m_tready  | m_tuser = status, m_tdata = granted_address
//
// a request passes through stack top read, index multiply and commit before its result
// a release runs the block index step (quotient, then leftover offset), then the walk
// through the stack ram read port, one entry per cycle, then commit
// reset needs no clearing pass: a low-water mark on the free count serves untouched entries
// a finished result sits in the output register while the next transfer is taken; the
// commit step waits there only if the previous result has not been taken yet

module fixed_block_pool_allocator_top
    import fbpa_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [ADDR_W-1:0] s_tdata,   // [31:0] block_address
    input  logic [0:0]        s_tuser,   // [0] command
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [ADDR_W-1:0] m_tdata,   // [31:0] granted_address
    output logic [1:0]        m_tuser    // [1:0] status
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    status_t   status;

    fbpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_free  (s_tuser[0]),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fbpa_dp #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_free    (s_tuser[0]),
        .in_addr    (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (status),
        .out_addr   (m_tdata)
    );

    assign m_tuser = status;

endmodule

// ----- hw/rtl/fbpa_ram.sv -----
`timescale 1ns / 1ps

module fbpa_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/fbpa_ctrl.sv -----
`timescale 1ns / 1ps

module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_free,
    output logic      in_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_WALK = 6'b000100,
        S_READ = 6'b001000,
        S_MUL  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (in_free == CMD_FREE) ? S_DIV : S_READ;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (sts.walk_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.top_read = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/fbpa_dp.sv -----
`timescale 1ns / 1ps

module fbpa_dp
    import fbpa_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_wdata,
    input  logic              in_free,
    input  logic [ADDR_W-1:0] in_addr,
    input  ctrl_cmd_t         cmd,
    output ctrl_sts_t         sts,
    output logic              out_valid,
    input  logic              out_ready,
    output status_t           out_status,
    output logic [ADDR_W-1:0] out_addr
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int SPAN_W  = $clog2(NUM_BLOCKS * BLOCK_BYTES);
    localparam int SHIFT   = SPAN_W + $clog2(BLOCK_BYTES);
    localparam int RECIP_W = SPAN_W + 2;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam logic [ADDR_W-1:0] POOL_SPAN  = ADDR_W'(NUM_BLOCKS * BLOCK_BYTES);
    localparam logic [ADDR_W-1:0] BB         = ADDR_W'(BLOCK_BYTES);
    localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(NUM_BLOCKS);

    logic [ADDR_W-1:0] base_reg,    base_next;
    logic              free_reg,    free_next;
    logic [ADDR_W-1:0] rem_reg,     rem_next;
    logic              range_reg,   range_next;
    logic              dstep_reg,   dstep_next;
    logic [IDX_W-1:0]  quo_reg,     quo_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [CNT_W-1:0]  lwm_reg,     lwm_next;
    logic [CNT_W-1:0]  walk_reg,    walk_next;
    logic              pend_reg,    pend_next;
    logic              found_reg,   found_next;
    logic [IDX_W-1:0]  rdk_reg,     rdk_next;
    logic              low_reg,     low_next;
    logic [ADDR_W-1:0] prod_reg,    prod_next;
    logic              ovalid_reg,  ovalid_next;
    status_t           ostat_reg,   ostat_next;
    logic [ADDR_W-1:0] oaddr_reg,   oaddr_next;

    logic [ADDR_W-1:0]         off;
    logic [SPAN_W+RECIP_W-1:0] recip_prod;
    logic [CNT_W-1:0]          top;
    logic [IDX_W-1:0]          raddr;
    logic [IDX_W-1:0]          rdata;
    logic [IDX_W-1:0]          entry;
    logic                      ram_we;

    assign off        = in_addr - base_reg;
    assign recip_prod = {{RECIP_W{1'b0}}, rem_reg[SPAN_W-1:0]} * {{SPAN_W{1'b0}}, RECIP};
    assign top        = count_reg - CNT_W'(1);
    assign raddr      = cmd.top_read ? top[IDX_W-1:0] : walk_reg[IDX_W-1:0];
    assign entry      = low_reg ? rdk_reg : rdata;

    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_BLOCKS),
        .AW    (IDX_W)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (quo_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            count_reg  <= CNT_FULL;
            lwm_reg    <= CNT_FULL;
            walk_reg   <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            base_reg   <= base_next;
            count_reg  <= count_next;
            lwm_reg    <= lwm_next;
            walk_reg   <= walk_next;
            pend_reg   <= pend_next;
            found_reg  <= found_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_reg  <= free_next;
        rem_reg   <= rem_next;
        range_reg <= range_next;
        dstep_reg <= dstep_next;
        quo_reg   <= quo_next;
        rdk_reg   <= rdk_next;
        low_reg   <= low_next;
        prod_reg  <= prod_next;
        ostat_reg <= ostat_next;
        oaddr_reg <= oaddr_next;
    end

    always_comb
    begin
        base_next   = base_reg;
        free_next   = free_reg;
        rem_next    = rem_reg;
        range_next  = range_reg;
        dstep_next  = dstep_reg;
        quo_next    = quo_reg;
        count_next  = count_reg;
        lwm_next    = lwm_reg;
        walk_next   = walk_reg;
        pend_next   = pend_reg;
        found_next  = found_reg;
        rdk_next    = rdk_reg;
        low_next    = low_reg;
        prod_next   = prod_reg;
        ovalid_next = ovalid_reg;
        ostat_next  = ostat_reg;
        oaddr_next  = oaddr_reg;
        ram_we      = 1'b0;

        if (cfg_we)
        begin
            base_next = cfg_wdata;
        end

        if (out_ready)
        begin
            ovalid_next = 1'b0;
        end

        if (cmd.load)
        begin
            free_next  = in_free;
            rem_next   = off;
            range_next = (off < POOL_SPAN);
            dstep_next = 1'b0;
            quo_next   = '0;
            walk_next  = '0;
            pend_next  = 1'b0;
            found_next = 1'b0;
        end

        // block index by reciprocal multiply, then the leftover offset
        if (cmd.div_step)
        begin
            dstep_next = 1'b1;
            if (!dstep_reg)
            begin
                quo_next = recip_prod[SHIFT +: IDX_W];
            end
            else
            begin
                rem_next = rem_reg - ADDR_W'(quo_reg) * BB;
            end
        end

        if (cmd.walk_step)
        begin
            pend_next = (walk_reg < count_reg);
            if (walk_reg < count_reg)
            begin
                walk_next = walk_reg + CNT_W'(1);
                rdk_next  = walk_reg[IDX_W-1:0];
                low_next  = (walk_reg < lwm_reg);
            end
            if (pend_reg && (entry == quo_reg))
            begin
                found_next = 1'b1;
            end
        end

        if (cmd.top_read)
        begin
            rdk_next = top[IDX_W-1:0];
            low_next = (top < lwm_reg);
        end

        if (cmd.mul)
        begin
            prod_next = ADDR_W'(entry * BB);
        end

        if (cmd.commit)
        begin
            ovalid_next = 1'b1;
            oaddr_next  = '0;
            if (free_reg == CMD_ALLOC)
            begin
                if (count_reg == '0)
                begin
                    ostat_next = ST_EMPTY;
                end
                else
                begin
                    ostat_next = ST_OK;
                    oaddr_next = base_reg + prod_reg;
                    count_next = top;
                    if (lwm_reg == count_reg)
                    begin
                        lwm_next = top;
                    end
                end
            end
            else
            begin
                if (!range_reg || (rem_reg != '0) || found_reg || (count_reg == CNT_FULL))
                begin
                    ostat_next = ST_REFUSED;
                end
                else
                begin
                    ostat_next = ST_OK;
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    assign sts.div_last  = dstep_reg;
    assign sts.walk_done = (walk_reg == count_reg) && !pend_reg;
    assign sts.out_free  = !ovalid_reg || out_ready;

    assign out_valid  = ovalid_reg;
    assign out_status = ostat_reg;
    assign out_addr   = oaddr_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("free count above pool size");

    a_lwm_order: assert property (@(posedge clk) disable iff (!rst_n)
        lwm_reg <= count_reg)
        else $error("low-water mark above free count");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (count_reg < CNT_FULL) && !found_reg && range_reg)
        else $error("push into full stack or of an invalid block");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (free_reg == CMD_ALLOC) && (count_reg != '0))
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("grant did not pop the stack");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free && !cmd.walk_step && !cmd.div_step)
        else $error("result committed over a waiting transfer");

endmodule

// ----- verif/fbpa_checker.sv -----
`timescale 1ns / 1ps

module fbpa_checker
    import fbpa_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [ADDR_W-1:0] s_tdata,
    input  logic [0:0]        s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [ADDR_W-1:0] m_tdata,
    input  logic [1:0]        m_tuser,
    output int                outstanding,
    output int                fail_count
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] addr;
    } outcome_t;

    logic [ADDR_W-1:0] pool_base;
    logic [IDX_W-1:0]  free_idx [NUM_BLOCKS];
    logic [IDX_W:0]    free_cnt;
    outcome_t          outcome_q [$];
    int                errs = 0;

    assign fail_count = errs;

    // pop or push the free stack and work out the answer
    function automatic outcome_t serve(input logic cmd, input logic [ADDR_W-1:0] addr);
        outcome_t          res;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] blk;
        logic              already_free;
        res.status = ST_OK;
        res.addr   = '0;
        if (cmd == CMD_ALLOC)
        begin
            if (free_cnt == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                free_cnt = free_cnt - 1'b1;
                res.addr = pool_base
                         + ADDR_W'(free_idx[free_cnt]) * ADDR_W'(BLOCK_BYTES);
            end
        end
        else
        begin
            off          = addr - pool_base;
            blk          = off / ADDR_W'(BLOCK_BYTES);
            already_free = 1'b0;
            for (int k = 0; k < NUM_BLOCKS; k++)
            begin
                if (k < free_cnt && ADDR_W'(free_idx[k]) == blk)
                    already_free = 1'b1;
            end
            if ((off % ADDR_W'(BLOCK_BYTES)) != 0 || blk >= ADDR_W'(NUM_BLOCKS)
                || already_free || free_cnt >= NUM_BLOCKS)
            begin
                res.status = ST_REFUSED;
            end
            else
            begin
                free_idx[free_cnt] = blk[IDX_W-1:0];
                free_cnt           = free_cnt + 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        if (!rst_n)
        begin
            pool_base = '0;
            for (int k = 0; k < NUM_BLOCKS; k++)
                free_idx[k] = k[IDX_W-1:0];
            free_cnt = (IDX_W+1)'(NUM_BLOCKS);
            outcome_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                pool_base = cfg_wdata;
            if (s_tvalid && s_tready)
                outcome_q.push_back(serve(s_tuser[0], s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (outcome_q.size() == 0)
                begin
                    errs++;
                    $display("%0t: result transfer with none pending, status %0d addr %h",
                             $time, m_tuser, m_tdata);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        errs++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                    end
                    if (m_tdata !== want.addr)
                    begin
                        errs++;
                        $display("%0t: granted_address expected %h actual %h",
                                 $time, want.addr, m_tdata);
                    end
                end
            end
            outstanding <= outcome_q.size();
        end
    end

endmodule

// ----- verif/tb_fixed_block_pool_allocator_top.sv -----
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator_top;
    import fbpa_pkg::*;

    localparam int NUM_BLOCKS  = NUM_BLOCKS_DEF;
    localparam int BLOCK_BYTES = BLOCK_BYTES_DEF;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [ADDR_W-1:0] cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [ADDR_W-1:0] s_tdata;
    logic [0:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [ADDR_W-1:0] m_tdata;
    logic [1:0]        m_tuser;

    int                outstanding;
    int                fail_count;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                sent_items;
    logic [ADDR_W-1:0] cur_base;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    fixed_block_pool_allocator_top #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    fbpa_checker #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // result side, with one long hold-off to back up the request side
    initial
    begin : result_sink
        bit held_off;
        held_off = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_off && sent_items >= 150)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] addr);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= addr;
        do @(posedge clk); while (!s_tready);
        sent_items++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_base(input logic [ADDR_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_base = value;
    endtask

    function automatic logic [ADDR_W-1:0] block_at(input int idx);
        return cur_base + ADDR_W'(idx) * ADDR_W'(BLOCK_BYTES);
    endfunction

    function automatic logic [ADDR_W-1:0] release_addr();
        int sel;
        sel = $urandom_range(99);
        if (sel < 65)
            return block_at($urandom_range(NUM_BLOCKS - 1));
        else if (sel < 78)
            return block_at($urandom_range(NUM_BLOCKS - 1)) + $urandom_range(1, BLOCK_BYTES - 1);
        else if (sel < 86)
            return block_at(NUM_BLOCKS + $urandom_range(0, 1000));
        else if (sel < 92)
            return block_at(-$urandom_range(1, 64));
        else
            return $urandom();
    endfunction

    // segments lean toward requests or releases so the pool drains and refills
    task automatic run_phase(input int n_items, input bit drain_first);
        int   req_pct;
        logic cmd;
        req_pct = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
            begin
                if (drain_first && i == 0)
                    req_pct = 100;
                else
                    case ($urandom_range(2))
                        0:       req_pct = 10;
                        1:       req_pct = 50;
                        default: req_pct = 90;
                    endcase
            end
            cmd = ($urandom_range(99) < req_pct) ? CMD_ALLOC : CMD_FREE;
            send_item(cmd, (cmd == CMD_ALLOC) ? $urandom() : release_addr());
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_ALLOC;
        cur_base       = '0;
        sent_items     = 0;
        send_idle_pct  = 20;
        recv_stall_pct = 54;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // double free right after reset, grants from the top, bad addresses
        send_item(CMD_FREE,  32'h0000_0000);
        send_item(CMD_ALLOC, 32'hFFFF_FFFF);
        send_item(CMD_ALLOC, 32'h0000_0000);
        send_item(CMD_FREE,  block_at(NUM_BLOCKS - 1));
        send_item(CMD_FREE,  block_at(NUM_BLOCKS - 1));
        send_item(CMD_FREE,  block_at(NUM_BLOCKS - 2) + 1);
        send_item(CMD_FREE,  block_at(NUM_BLOCKS));
        send_item(CMD_FREE,  block_at(-1));
        send_item(CMD_FREE,  32'hFFFF_FFFF);
        send_item(CMD_FREE,  block_at(NUM_BLOCKS - 2) + BLOCK_BYTES - 1);
        send_item(CMD_FREE,  block_at(NUM_BLOCKS - 2));
        send_item(CMD_ALLOC, 32'h5555_5555);
        send_item(CMD_FREE,  32'hAAAA_AA80);
        run_phase(300, 1'b1);

        // blocks straddle the top of the address space
        write_base(32'hFFFF_F800);
        send_item(CMD_ALLOC, 32'h0000_0000);
        send_item(CMD_FREE,  32'h0000_0000);
        send_item(CMD_FREE,  32'h0000_0780);
        send_item(CMD_FREE,  32'hFFFF_F780);
        send_item(CMD_FREE,  32'h0000_0800);
        run_phase(330, 1'b0);

        send_idle_pct  = 54;
        recv_stall_pct = 20;
        write_base(32'hFFFF_FFFF);
        run_phase(330, 1'b1);
        write_base(32'h0000_0000);
        run_phase(330, 1'b0);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_base($urandom());
        run_phase(330, 1'b1);
        write_base(32'h0000_1000);
        run_phase(330, 1'b0);

        drain_results();
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("[fixed_block_pool_allocator_top] OK");
        else
            $display("[fixed_block_pool_allocator_top] ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[fixed_block_pool_allocator_top] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_ram.sv
hw/rtl/fbpa_ctrl.sv
hw/rtl/fbpa_dp.sv
hw/rtl/fixed_block_pool_allocator_top.sv
verif/fbpa_checker.sv
verif/tb_fixed_block_pool_allocator_top.sv
